// File: rtl/bpdc_pkg.sv
// Shared types and constants for the button press duration classifier.
package bpdc_pkg;

    // Per-button phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RAW      = 3'd1;
    localparam logic [2:0] PH_SHORT    = 3'd2;
    localparam logic [2:0] PH_LONG     = 3'd3;
    localparam logic [2:0] PH_HELD     = 3'd4;
    localparam logic [2:0] PH_UP_SHORT = 3'd5;
    localparam logic [2:0] PH_UP_LONG  = 3'd6;
    localparam logic [2:0] PH_UP_HELD  = 3'd7;

    localparam int PHASE_W  = 3;
    localparam int TIMER_W  = 16;
    localparam int STEP_W   = 8;
    localparam int THRESH_W = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_THRESHOLD  = 8'd3;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]   RST_STEP_SIZE       = 8'd1;
    localparam logic [THRESH_W-1:0] RST_SHORT_THRESHOLD = 15'd50;
    localparam logic [THRESH_W-1:0] RST_LONG_THRESHOLD  = 15'd200;
    localparam logic [THRESH_W-1:0] RST_HELD_THRESHOLD  = 15'd600;

    // Settings shared by every lane
    typedef struct packed {
        logic [STEP_W-1:0]   step_size;
        logic [THRESH_W-1:0] short_threshold;
        logic [THRESH_W-1:0] long_threshold;
        logic [THRESH_W-1:0] held_threshold;
    } t_cfg;

endpackage

// File: rtl/bpdc_lane.sv
// One button lane: phase machine and press timer for a single button.
module bpdc_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick,
    input  logic                             i_released,
    input  bpdc_pkg::t_cfg                   i_cfg,
    output logic [bpdc_pkg::PHASE_W-1:0]     o_phase,
    output logic                             o_event
);

    logic [bpdc_pkg::PHASE_W-1:0] r_phase;
    logic [bpdc_pkg::PHASE_W-1:0] n_phase;
    logic [bpdc_pkg::TIMER_W-1:0] r_timer;
    logic [bpdc_pkg::TIMER_W-1:0] n_timer;
    logic [bpdc_pkg::TIMER_W-1:0] w_sum;
    logic                         n_event;

    // Advance the timer by the step, wrapping at the timer width
    assign w_sum = r_timer + {{(bpdc_pkg::TIMER_W-bpdc_pkg::STEP_W){1'b0}}, i_cfg.step_size};

    // Next phase, timer and event for this tick
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_event = 1'b0;
        if (!i_released) begin
            if (r_phase == bpdc_pkg::PH_IDLE) begin
                n_phase = bpdc_pkg::PH_RAW;
            end else begin
                n_timer = w_sum;
                if (w_sum == {1'b0, i_cfg.short_threshold}) begin
                    n_phase = bpdc_pkg::PH_SHORT;
                    n_event = 1'b1;
                end
                if (w_sum == {1'b0, i_cfg.long_threshold}) begin
                    n_phase = bpdc_pkg::PH_LONG;
                    n_event = 1'b1;
                end
                if (w_sum >= {1'b0, i_cfg.held_threshold}) begin
                    n_timer = {1'b0, i_cfg.held_threshold};
                    n_phase = bpdc_pkg::PH_HELD;
                    n_event = 1'b1;
                end
            end
        end else if (r_phase != bpdc_pkg::PH_IDLE) begin
            n_timer = '0;
            unique case (r_phase)
                bpdc_pkg::PH_SHORT: begin
                    n_phase = bpdc_pkg::PH_UP_SHORT;
                    n_event = 1'b1;
                end
                bpdc_pkg::PH_LONG: begin
                    n_phase = bpdc_pkg::PH_UP_LONG;
                    n_event = 1'b1;
                end
                bpdc_pkg::PH_HELD: begin
                    n_phase = bpdc_pkg::PH_UP_HELD;
                    n_event = 1'b1;
                end
                default: begin
                    n_phase = bpdc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Commit state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bpdc_pkg::PH_IDLE;
            r_timer <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

    assign o_phase = n_phase;
    assign o_event = n_event;

endmodule

// File: rtl/bpdc_merge.sv
// Merge stage: gathers lane results into one word behind an output register and skid slot.
module bpdc_merge #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_tick,
    input  logic [NUM_BUTTONS-1:0]                    i_events,
    input  logic [NUM_BUTTONS*bpdc_pkg::PHASE_W-1:0]  i_phases,
    output logic                                      o_ready,
    output logic                                      o_valid,
    input  logic                                      i_taken,
    output logic [NUM_BUTTONS-1:0]                    o_events,
    output logic [NUM_BUTTONS*bpdc_pkg::PHASE_W-1:0]  o_phases
);

    localparam int WORD_W = NUM_BUTTONS * (1 + bpdc_pkg::PHASE_W);

    logic              r_out_valid;
    logic              r_skid_valid;
    logic [WORD_W-1:0] r_out;
    logic [WORD_W-1:0] r_skid;
    logic [WORD_W-1:0] w_new;
    logic              w_pop;

    assign w_new   = {i_phases, i_events};
    assign w_pop   = r_out_valid && i_taken;
    assign o_ready = !r_skid_valid;

    // Track which slots hold a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_tick;
                end
            end else if (i_tick) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Move payload between slots
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_tick) begin
                r_out <= w_new;
            end
        end else if (i_tick) begin
            if (r_out_valid) begin
                r_skid <= w_new;
            end else begin
                r_out <= w_new;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_events = r_out[NUM_BUTTONS-1:0];
    assign o_phases = r_out[WORD_W-1:NUM_BUTTONS];

endmodule

// File: rtl/button_press_duration_classifier.sv
// Top level of the button press duration classifier: config registers, lanes and merge.
// Result words are held in the merge output register, or in the skid slot while it waits.
// Throughput: one scan word per cycle while the skid slot is free; all button lanes update in parallel each word.
// The output register plus a one-word skid slot let input accept while a result waits.
// Reset (synchronous, active low): all buttons idle, timers zero, registers to defaults,
// output empty.
module button_press_duration_classifier #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Scan input
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    input  logic [((NUM_BUTTONS+7)/8)*8-1:0]        i_s_tdata,  // release_levels
    // Result output
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [((NUM_BUTTONS*4+7)/8)*8-1:0]      o_m_tdata,  // event_mask, packed_states
    // Configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int FIELD_W = NUM_BUTTONS * 4;
    localparam int PH_W    = NUM_BUTTONS * bpdc_pkg::PHASE_W;

    bpdc_pkg::t_cfg r_cfg;

    logic                   w_tick;
    logic                   w_ready;
    logic [NUM_BUTTONS-1:0] w_events;
    logic [PH_W-1:0]        w_phases;
    logic [NUM_BUTTONS-1:0] w_out_events;
    logic [PH_W-1:0]        w_out_phases;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size       <= bpdc_pkg::RST_STEP_SIZE;
            r_cfg.short_threshold <= bpdc_pkg::RST_SHORT_THRESHOLD;
            r_cfg.long_threshold  <= bpdc_pkg::RST_LONG_THRESHOLD;
            r_cfg.held_threshold  <= bpdc_pkg::RST_HELD_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpdc_pkg::CFG_STEP_SIZE:
                    r_cfg.step_size <= i_cfg_data[bpdc_pkg::STEP_W-1:0];
                bpdc_pkg::CFG_SHORT_THRESHOLD:
                    r_cfg.short_threshold <= i_cfg_data[bpdc_pkg::THRESH_W-1:0];
                bpdc_pkg::CFG_LONG_THRESHOLD:
                    r_cfg.long_threshold <= i_cfg_data[bpdc_pkg::THRESH_W-1:0];
                bpdc_pkg::CFG_HELD_THRESHOLD:
                    r_cfg.held_threshold <= i_cfg_data[bpdc_pkg::THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign o_s_tready = w_ready;
    assign w_tick     = i_s_tvalid && w_ready;

    // One lane per button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bpdc_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tick     (w_tick),
            .i_released (i_s_tdata[g]),
            .i_cfg      (r_cfg),
            .o_phase    (w_phases[g*bpdc_pkg::PHASE_W +: bpdc_pkg::PHASE_W]),
            .o_event    (w_events[g])
        );
    end

    // Combine lane results into the result word
    bpdc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_events (w_events),
        .i_phases (w_phases),
        .o_ready  (w_ready),
        .o_valid  (o_m_tvalid),
        .i_taken  (i_m_tready),
        .o_events (w_out_events),
        .o_phases (w_out_phases)
    );

    // Pack result fields, padded to whole bytes
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[FIELD_W-1:0] = {w_out_phases, w_out_events};
    end

endmodule
